@@ sv/ppid_pkg.sv @@
// Package: payload types and register indexes for the positional PID controller.
`timescale 1ns / 1ps
package ppid_pkg;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               arrived;
  } out_item_t;

  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_OUT_LIMIT = 3'd3;
  localparam logic [2:0] REG_I_RANGE   = 3'd4;
  localparam logic [2:0] REG_I_MAX     = 3'd5;
  localparam logic [2:0] REG_ERR_TOL   = 3'd6;
  localparam logic [2:0] REG_D_TOL     = 3'd7;

  localparam logic [30:0] I_RANGE_RST = 31'd3276800;
  localparam logic [30:0] I_MAX_RST   = 31'd1310720;

  localparam int SUM_W = 40;

endpackage

@@ sv/positional_pid_controller.sv @@
// Top level: positional PID controller with integral separation, Q16.16.
//
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_ready   | ppid_pkg::in_item_t (setpoint, measured, restart)
//  out     | out | out_valid/out_ready | ppid_pkg::out_item_t (drive, arrived)
//  cfg     | in  | cfg_we              | cfg_index[2:0], cfg_data[31:0]
//
// After an item is accepted it passes through the steps error, P product, D product,
// sums, the divide step (the 47-bit quotient of the integral bound), clamp, the two
// integral products, the adds and the output limit; four products share one 32x32 multiplier.
// in_ready is high only when idle, so the next item is accepted only once the previous
// one has left its output step. A result not yet taken holds the sequencer in its output
// step; the next item is not accepted meanwhile.
// rst is synchronous: gains 0, i_range 50.0, i_max 20.0, first_sample set, sum cleared.
`timescale 1ns / 1ps
module positional_pid_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ppid_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ppid_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_MP    = 4'd2;
  localparam logic [3:0] S_MD    = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_CLAMP = 4'd6;
  localparam logic [3:0] S_MIH   = 4'd7;
  localparam logic [3:0] S_MIL   = 4'd8;
  localparam logic [3:0] S_ADD   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // configuration registers
  logic signed [31:0] gain_p, gain_i, gain_d;
  logic [30:0] out_limit, i_range, i_max, err_tol, d_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= '0;
      gain_i    <= '0;
      gain_d    <= '0;
      out_limit <= '0;
      i_range   <= ppid_pkg::I_RANGE_RST;
      i_max     <= ppid_pkg::I_MAX_RST;
      err_tol   <= '0;
      d_tol     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppid_pkg::REG_GAIN_P:    gain_p    <= cfg_data;
        ppid_pkg::REG_GAIN_I:    gain_i    <= cfg_data;
        ppid_pkg::REG_GAIN_D:    gain_d    <= cfg_data;
        ppid_pkg::REG_OUT_LIMIT: out_limit <= cfg_data[30:0];
        ppid_pkg::REG_I_RANGE:   i_range   <= cfg_data[30:0];
        ppid_pkg::REG_I_MAX:     i_max     <= cfg_data[30:0];
        ppid_pkg::REG_ERR_TOL:   err_tol   <= cfg_data[30:0];
        ppid_pkg::REG_D_TOL:     d_tol     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic [3:0] state;
  logic       first_sample;
  logic signed [31:0] last_error;
  logic signed [39:0] error_sum;
  ppid_pkg::in_item_t in_lat;

  // working registers
  logic signed [31:0] err, derr;
  logic signed [47:0] p_term, d_term;
  logic signed [55:0] acc;
  logic signed [40:0] sum_w;
  logic        sep;

  // shared multiplier: 32-bit signed by 32-bit signed
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [47:0] prod_q;
  assign prod   = mul_a * mul_b;
  assign prod_q = prod[63:16];

  // integral is split into whole part times gain plus floored fraction times gain
  always_comb begin
    case (state)
      S_MP:    begin mul_a = err;  mul_b = gain_p; end
      S_MD:    begin mul_a = derr; mul_b = gain_d; end
      S_MIH:   begin mul_a = {{8{error_sum[39]}}, error_sum[39:16]}; mul_b = gain_i; end
      S_MIL:   begin mul_a = {16'd0, error_sum[15:0]}; mul_b = gain_i; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // error and derivative with saturation
  logic signed [32:0] e_raw, de_raw;
  logic signed [31:0] e_sat, le_eff, de_sat;
  assign e_raw  = 33'(in_lat.setpoint) - 33'(in_lat.measured);
  assign e_sat  = (e_raw > 33'sd2147483647) ? 32'sh7fffffff :
                  (e_raw < -33'sd2147483648) ? 32'sh80000000 : e_raw[31:0];
  assign le_eff = (first_sample || in_lat.restart) ? e_sat : last_error;
  assign de_raw = 33'(e_sat) - 33'(le_eff);
  assign de_sat = (de_raw > 33'sd2147483647) ? 32'sh7fffffff :
                  (de_raw < -33'sd2147483648) ? 32'sh80000000 : de_raw[31:0];

  logic [31:0] e_mag;
  assign e_mag = err[31] ? 32'(-33'(err)) : err;
  logic [47:0] p_mag;
  assign p_mag = p_term[47] ? -p_term : p_term;

  // divider for the integral bound
  logic        div_start, div_done, div_busy;
  logic [46:0] div_q;
  ppid_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({i_max, 16'd0}), .den(gain_i[30:0]),
    .done(div_done), .quo(div_q)
  );
  assign div_start = (state == S_DIV) && !div_busy;

  // sum saturation and clamp
  logic signed [40:0] s_sat;
  assign s_sat = (sum_w > 41'sd549755813887) ? 41'sd549755813887 :
                 (sum_w < -41'sd549755813888) ? -41'sd549755813888 : sum_w;
  logic [40:0] s_mag;
  assign s_mag = s_sat[40] ? -s_sat : s_sat;
  logic signed [40:0] s_cl;
  always_comb begin
    s_cl = s_sat;
    if (!gain_i[31] && gain_i != 0 && {6'd0, s_mag} > div_q)
      s_cl = s_sat[40] ? -41'(div_q) : 41'(div_q);
  end
  logic s_zero;
  assign s_zero = sep || (s_cl == 0 ? err != 0 :
                  (s_cl[40] != err[31]) || err == 0) || (e_mag <= {1'b0, err_tol});

  logic [55:0] y_mag;
  logic [47:0] d_mag;
  assign y_mag = acc[55] ? -acc : acc;
  assign d_mag = d_term[47] ? -d_term : d_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      first_sample <= 1'b1;
      last_error   <= '0;
      error_sum    <= '0;
      out_valid    <= 1'b0;
      div_busy     <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) state <= S_ERR;
        S_ERR: begin
          err <= e_sat;
          derr <= de_sat;
          last_error <= e_sat;
          if (first_sample || in_lat.restart) error_sum <= '0;
          first_sample <= 1'b0;
          state <= S_MP;
        end
        S_MP: begin p_term <= prod_q; state <= S_MD; end
        S_MD: begin
          d_term <= prod_q;
          sep    <= (p_mag >= {17'd0, i_range});
          sum_w  <= 41'(error_sum) + 41'(err);
          state  <= S_SUM;
        end
        S_SUM: state <= S_DIV;
        S_DIV: begin
          if (!div_busy) div_busy <= 1'b1;
          else if (div_done) begin div_busy <= 1'b0; state <= S_CLAMP; end
        end
        S_CLAMP: begin
          error_sum <= s_zero ? 40'sd0 : s_cl[39:0];
          state <= S_MIH;
        end
        S_MIH: begin acc <= prod[55:0]; state <= S_MIL; end
        S_MIL: begin
          acc <= acc + 56'(prod_q);
          state <= S_ADD;
        end
        S_ADD: begin
          acc <= acc + 56'(p_term) + 56'(d_term);
          state <= S_OUT;
        end
        S_OUT: begin
          // wait here while the previous result is still unread
          if (!out_valid || out_ready) begin
            if (y_mag > {25'd0, out_limit})
              out_item.drive <= acc[55] ? -32'(out_limit) : 32'(out_limit);
            else
              out_item.drive <= acc[31:0];
            out_item.arrived <= (e_mag <= {1'b0, err_tol}) && (d_mag <= {17'd0, d_tol});
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_lat <= in_item;
  end

  assign in_ready = (state == S_IDLE);

  // checks
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_ERR)) else $error("no start");
  a_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> out_valid) else $error("result lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("result changed while waiting");

endmodule

@@ sv/ppid_div.sv @@
// Restoring divider, one quotient bit per cycle: floor(num / den), unsigned.
`timescale 1ns / 1ps
module ppid_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [46:0] num,
  input  logic [30:0] den,
  output logic        done,
  output logic [46:0] quo
);

  logic [5:0]  cnt;
  logic        busy;
  logic [31:0] rem;
  logic [32:0] trial;

  assign trial = {rem, quo[46]} - {2'b0, den};

  // Shift numerator bits through the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd46) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[45:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[46]};
        quo <= {quo[45:0], 1'b0};
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench for the positional PID controller: directed table, random samples, predictor.
`timescale 1ns / 1ps
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ppid_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ppid_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = ppid_pkg::REG_GAIN_P;
  logic [31:0] cfg_data = '0;

  positional_pid_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Controller settings and state as tracked by the predictor
  longint kp, ki, kd, lim_out, sep_range, int_max, tol_err, tol_d;
  bit first_pending;
  longint prev_err, err_acc;

  localparam longint ACC_MAX = 64'sd549755813887;
  localparam longint ACC_MIN = -64'sd549755813888;

  ppid_pkg::out_item_t drive_queue[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint abs64(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic int sign_of(longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  // floor(x / 65536); arithmetic shift rounds toward minus infinity
  function automatic longint q_floor(longint x);
    return x >>> 16;
  endfunction

  function automatic void reset_model();
    kp = 0; ki = 0; kd = 0; lim_out = 0;
    sep_range = 3276800; int_max = 1310720; tol_err = 0; tol_d = 0;
    first_pending = 1'b1; prev_err = 0; err_acc = 0;
  endfunction

  // Computes one controller output and advances the tracked state
  function automatic ppid_pkg::out_item_t pid_output(ppid_pkg::in_item_t it);
    longint e, de, p, d, i, y, s, bound, hi, lo;
    ppid_pkg::out_item_t r;
    e = clip32(longint'(it.setpoint) - longint'(it.measured));
    if (it.restart) first_pending = 1'b1;
    p = q_floor(kp * e);
    if (first_pending) begin
      first_pending = 1'b0;
      prev_err = e;
      err_acc = 0;
    end
    de = clip32(e - prev_err);
    prev_err = e;
    d = q_floor(kd * de);
    if (abs64(p) >= sep_range) begin
      err_acc = 0;
    end else begin
      s = err_acc + e;
      if (s > ACC_MAX) s = ACC_MAX;
      if (s < ACC_MIN) s = ACC_MIN;
      if (ki > 0) begin
        bound = (int_max * 65536) / ki;
        if (abs64(s) > bound) s = (s < 0) ? -bound : bound;
      end
      err_acc = s;
    end
    if (sign_of(err_acc) != sign_of(e) || abs64(e) <= tol_err) err_acc = 0;
    // split product keeps the 40x32 multiply inside 64 bits
    hi = q_floor(err_acc);
    lo = err_acc - hi * 65536;
    i = hi * ki + q_floor(lo * ki);
    y = p + i + d;
    if (abs64(y) > lim_out) y = (y < 0) ? -lim_out : lim_out;
    r.drive = y[31:0];
    r.arrived = (abs64(e) <= tol_err) && (abs64(d) <= tol_d);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  // Result checker
  always @(posedge clk) begin
    ppid_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_queue.size() == 0) begin
        report("unexpected item", out_item.drive, 32'h0);
      end else begin
        want = drive_queue.pop_front();
        if (out_item.drive !== want.drive) report("drive", out_item.drive, want.drive);
        if (out_item.arrived !== want.arrived)
          report("arrived", 32'(out_item.arrived), 32'(want.arrived));
      end
    end
  end

  // Receiver stall
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ppid_pkg::REG_GAIN_P:    kp = longint'(signed'(val));
      ppid_pkg::REG_GAIN_I:    ki = longint'(signed'(val));
      ppid_pkg::REG_GAIN_D:    kd = longint'(signed'(val));
      ppid_pkg::REG_OUT_LIMIT: lim_out = longint'(val[30:0]);
      ppid_pkg::REG_I_RANGE:   sep_range = longint'(val[30:0]);
      ppid_pkg::REG_I_MAX:     int_max = longint'(val[30:0]);
      ppid_pkg::REG_ERR_TOL:   tol_err = longint'(val[30:0]);
      default:                 tol_d = longint'(val[30:0]);
    endcase
  endtask

  // Sends one sample; an explicit expected result overrides the predictor
  task automatic send(ppid_pkg::in_item_t it, bit fixed, ppid_pkg::out_item_t want);
    ppid_pkg::out_item_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = pid_output(it);
    drive_queue.push_back(fixed ? want : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sd65536 * $signed($urandom_range(200)) - 32'sd6553600;
      2: return $urandom_range(131072) - 65536;
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(4000000)) - 2000000);
    endcase
  endfunction

  task automatic random_config(int mode);
    write_reg(ppid_pkg::REG_GAIN_P,
              mode == 0 ? $urandom : 32'($urandom_range(196608)) - 32'd65536);
    write_reg(ppid_pkg::REG_GAIN_I,
              mode == 0 ? $urandom : 32'($urandom_range(65536)) - 32'd8192);
    write_reg(ppid_pkg::REG_GAIN_D,
              mode == 0 ? $urandom : 32'($urandom_range(131072)) - 32'd32768);
    write_reg(ppid_pkg::REG_OUT_LIMIT, mode == 0 ? 32'h7fffffff : $urandom);
    write_reg(ppid_pkg::REG_I_RANGE,
              $urandom_range(1) ? $urandom : 32'($urandom_range(10000000)));
    write_reg(ppid_pkg::REG_I_MAX,
              $urandom_range(1) ? $urandom : 32'($urandom_range(5000000)));
    write_reg(ppid_pkg::REG_ERR_TOL, 32'($urandom_range(200000)));
    write_reg(ppid_pkg::REG_D_TOL,
              $urandom_range(3) == 0 ? 32'h7fffffff : 32'($urandom_range(300000)));
  endtask

  typedef struct {
    logic [31:0] sp;
    logic [31:0] ms;
    bit rs;
    bit fixed;
    logic [31:0] drive;
    bit arrived;
  } row_t;

  // Directed samples: the first under reset registers, the rest under two sets of gains
  row_t dir_rows[15] = '{
    '{32'h0, 32'h0, 1'b1, 1'b1, 32'h0, 1'b1},
    '{32'h7fffffff, 32'h80000000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h80000000, 32'h7fffffff, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h00010000, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0},
    '{32'h00020000, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h00030000, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0, 32'h00010000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h00000800, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h00400000, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'hffffffff, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h80000000, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0},
    '{32'h7fffffff, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h12345678, 32'hfedcba98, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0}
  };

  initial begin
    ppid_pkg::in_item_t it;
    ppid_pkg::out_item_t want;
    int n;
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: gains zero and limit zero give a zero drive
    for (int k = 0; k < $size(dir_rows); k++) begin
      if (k == 1) begin
        drain();
        write_reg(ppid_pkg::REG_GAIN_P, 32'h00020000);
        write_reg(ppid_pkg::REG_GAIN_I, 32'h00008000);
        write_reg(ppid_pkg::REG_GAIN_D, 32'hffff0000);
        write_reg(ppid_pkg::REG_OUT_LIMIT, 32'h7fffffff);
        write_reg(ppid_pkg::REG_I_RANGE, 32'h00080000);
        write_reg(ppid_pkg::REG_I_MAX, 32'h00010000);
        write_reg(ppid_pkg::REG_ERR_TOL, 32'h00001000);
        write_reg(ppid_pkg::REG_D_TOL, 32'h00002000);
      end
      if (k == 11) begin
        drain();
        write_reg(ppid_pkg::REG_GAIN_P, 32'h80000000);
        write_reg(ppid_pkg::REG_GAIN_I, 32'h7fffffff);
        write_reg(ppid_pkg::REG_GAIN_D, 32'h7fffffff);
        write_reg(ppid_pkg::REG_I_RANGE, 32'h7fffffff);
        write_reg(ppid_pkg::REG_I_MAX, 32'h7fffffff);
        write_reg(ppid_pkg::REG_ERR_TOL, 32'h0);
        write_reg(ppid_pkg::REG_D_TOL, 32'h7fffffff);
      end
      it.setpoint = dir_rows[k].sp;
      it.measured = dir_rows[k].ms;
      it.restart = dir_rows[k].rs;
      want.drive = dir_rows[k].drive;
      want.arrived = dir_rows[k].arrived;
      send(it, dir_rows[k].fixed, want);
    end

    // Random phases: receiver idles more, then sender idles more, then neither idles
    for (int ph = 0; ph < 9; ph++) begin
      drain();
      send_idle = (ph < 3) ? 33 : ((ph < 6) ? 49 : 0);
      recv_idle = (ph < 3) ? 49 : ((ph < 6) ? 33 : 0);
      random_config(ph % 3);
      n = 0;
      while (n < 82) begin
        it.setpoint = rand_q();
        it.measured = ($urandom_range(2) == 0) ? rand_q() : it.setpoint - rand_q() / 64;
        it.restart = ($urandom_range(24) == 0);
        send(it, 1'b0, want);
        n++;
        // hold off until the controller has answered everything
        if (ph == 4 && n == 40) drain();
      end
    end

    drain();
    if (errors == 0) begin
      $display("positional_pid_controller: match");
    end else begin
      $display("positional_pid_controller: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("positional_pid_controller: mismatch");
    $finish;
  end

endmodule
